@@ design/sdbs_pkg.sv @@
package sdbs_pkg;

  // Field widths fixed by the pixel format
  localparam int unsigned PixW   = 8;
  localparam int unsigned IndexW = 17;
  localparam int unsigned GainW  = 4;
  localparam int unsigned ProdW  = PixW + GainW;

  // Configuration register map
  localparam int unsigned CfgIdxW = 2;
  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_VARIANCE_FLOOR   = 2'd0;
  localparam cfg_idx_t CFG_VARIANCE_CEILING = 2'd1;
  localparam cfg_idx_t CFG_DIFFERENCE_GAIN  = 2'd2;

  // Register reset values
  localparam logic [PixW-1:0]  FloorReset   = 8'd20;
  localparam logic [PixW-1:0]  CeilingReset = 8'd254;
  localparam logic [GainW-1:0] GainReset    = 4'd2;
  localparam logic [PixW-1:0]  PixMax       = 8'd255;

  // Request codes
  localparam logic REQ_INIT   = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  // Per-pixel model word as kept in memory
  typedef struct packed {
    logic [PixW-1:0] bg;
    logic [PixW-1:0] var_lvl;
  } pixel_model_t;

  localparam int unsigned ModelW = $bits(pixel_model_t);

  // Move a level one step toward a target
  function automatic logic [PixW-1:0] step_toward(input logic [PixW-1:0] cur,
                                                  input logic [PixW-1:0] target);
    logic [PixW-1:0] res;
    res = cur;
    if (cur < target) begin
      res = cur + 8'd1;
    end else if (cur > target) begin
      res = cur - 8'd1;
    end
    return res;
  endfunction

endpackage

@@ design/sigma_delta_background_subtract_unit.sv @@
// Sigma-delta background estimator: per-pixel background and variance bytes live in one
// memory of PIXEL_COUNT words. It accepts one pixel transaction per clock while the result
// side is not stalled, in any index order: back-to-back transactions on the same pixel
// are resolved by forwarding from the two stages ahead. Each passes through the input
// register with memory read, the background stage and the variance stage into the output
// register. The memory is not cleared after reset: every pixel must see an init
// transaction before its first update, and indexes at or above PIXEL_COUNT read zero and
// store nothing. Configuration must be written while the pipeline is empty.
module sigma_delta_background_subtract_unit #(
  parameter int unsigned PIXEL_COUNT = 131072
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration
  input  logic                                cfg_we_i,
  input  sdbs_pkg::cfg_idx_t                  cfg_idx_i,
  input  logic [sdbs_pkg::PixW-1:0]           cfg_data_i,
  // Pixel input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic [sdbs_pkg::IndexW-1:0]         pixel_index_i,
  input  logic [sdbs_pkg::PixW-1:0]           pixel_value_i,
  // Result output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                foreground_o,
  output logic [sdbs_pkg::PixW-1:0]           background_level_o,
  output logic [sdbs_pkg::PixW-1:0]           variance_level_o
);

  import sdbs_pkg::*;

  localparam int unsigned AddrW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;

  // Configuration registers
  logic [PixW-1:0]  floor_q;
  logic [PixW-1:0]  ceiling_q;
  logic [GainW-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q   <= FloorReset;
      ceiling_q <= CeilingReset;
      gain_q    <= GainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VARIANCE_FLOOR:   floor_q   <= cfg_data_i;
        CFG_VARIANCE_CEILING: ceiling_q <= cfg_data_i;
        CFG_DIFFERENCE_GAIN:  gain_q    <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: all stages advance together
  logic advance;
  logic in_accept;
  logic in_range;

  logic s3_valid_q;

  assign advance    = !s3_valid_q || !out_stall_i;
  assign in_stall_o = !advance;
  assign in_accept  = in_valid_i && advance;
  assign in_range   = (32'(pixel_index_i) < PIXEL_COUNT);

  // Stage registers
  logic              s1_valid_q, s2_valid_q;
  logic              s1_req_q,   s2_req_q;
  logic [IndexW-1:0] s1_idx_q,   s2_idx_q,   s3_idx_q;
  logic              s1_inr_q,   s2_inr_q,   s3_inr_q;
  logic [PixW-1:0]   s1_pix_q;
  logic [PixW-1:0]   s2_bg_q,    s3_bg_q;
  logic [PixW-1:0]   s2_diff_q;
  logic [PixW-1:0]   s2_oldvar_q;
  logic              s2_use_prev_q;
  logic [PixW-1:0]   s3_var_q;
  logic              s3_fg_q;

  // Model memory
  pixel_model_t rd_model;
  pixel_model_t wr_model;
  logic         mem_we;

  sdbs_ram #(
    .Width (ModelW),
    .Depth (PIXEL_COUNT),
    .AddrW (AddrW)
  ) u_model_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(s2_idx_q)),
    .wdata_i (wr_model),
    .re_i    (in_accept && in_range),
    .raddr_i (AddrW'(pixel_index_i)),
    .rdata_o (rd_model)
  );

  // Stage 1: resolve the stored model with forwarding, step the background or load it on init
  logic            fwd_s2;
  logic            fwd_s3;
  logic [PixW-1:0] s1_old_bg;
  logic [PixW-1:0] s1_old_var;
  logic [PixW-1:0] s1_new_bg;
  logic [PixW-1:0] s1_diff;

  always_comb begin
    fwd_s2 = s2_valid_q && s2_inr_q && (s2_idx_q == s1_idx_q);
    fwd_s3 = s3_valid_q && s3_inr_q && (s3_idx_q == s1_idx_q);
    priority if (!s1_inr_q) begin
      s1_old_bg  = '0;
      s1_old_var = '0;
    end else if (fwd_s2) begin
      s1_old_bg  = s2_bg_q;
      s1_old_var = '0;
    end else if (fwd_s3) begin
      s1_old_bg  = s3_bg_q;
      s1_old_var = s3_var_q;
    end else begin
      s1_old_bg  = rd_model.bg;
      s1_old_var = rd_model.var_lvl;
    end
    if (s1_req_q == REQ_INIT) begin
      s1_new_bg = s1_pix_q;
    end else begin
      s1_new_bg = step_toward(s1_old_bg, s1_pix_q);
    end
    s1_diff = (s1_new_bg > s1_pix_q) ? (s1_new_bg - s1_pix_q) : (s1_pix_q - s1_new_bg);
  end

  // Stage 2: variance update, clamp and classify
  logic [PixW-1:0]  s2_old_var;
  logic [ProdW-1:0] s2_prod;
  logic [PixW-1:0]  s2_target;
  logic [PixW-1:0]  s2_var;
  logic             s2_fg;

  always_comb begin
    // The item one stage ahead of this one now sits in the output register
    s2_old_var = s2_use_prev_q ? s3_var_q : s2_oldvar_q;
    s2_prod    = ProdW'(s2_diff_q) * ProdW'(gain_q);
    s2_target  = (s2_prod > ProdW'(PixMax)) ? PixMax : s2_prod[PixW-1:0];
    if (s2_req_q == REQ_INIT) begin
      s2_var = floor_q;
      s2_fg  = 1'b0;
    end else begin
      s2_var = step_toward(s2_old_var, s2_target);
      if (s2_var > ceiling_q) begin
        s2_var = ceiling_q;
      end
      if (s2_var < floor_q) begin
        s2_var = floor_q;
      end
      s2_fg = (s2_diff_q >= s2_var);
    end
  end

  // Write back the updated model as the item leaves stage 2
  assign mem_we           = advance && s2_valid_q && s2_inr_q;
  assign wr_model.bg      = s2_bg_q;
  assign wr_model.var_lvl = s2_var;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // Payload: advance with the pipeline, hold on stall
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_req_q      <= req_type_i;
      s1_idx_q      <= pixel_index_i;
      s1_inr_q      <= in_range;
      s1_pix_q      <= pixel_value_i;

      s2_req_q      <= s1_req_q;
      s2_idx_q      <= s1_idx_q;
      s2_inr_q      <= s1_inr_q;
      s2_bg_q       <= s1_new_bg;
      s2_diff_q     <= s1_diff;
      s2_oldvar_q   <= s1_old_var;
      s2_use_prev_q <= s1_inr_q && fwd_s2;

      s3_idx_q      <= s2_idx_q;
      s3_inr_q      <= s2_inr_q;
      s3_bg_q       <= s2_bg_q;
      s3_var_q      <= s2_var;
      s3_fg_q       <= s2_fg;
    end
  end

  assign out_valid_o        = s3_valid_q;
  assign foreground_o       = s3_fg_q;
  assign background_level_o = s3_bg_q;
  assign variance_level_o   = s3_var_q;

endmodule

@@ design/sdbs_ram.sv @@
module sdbs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, hold data when not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ dv/sdbs_motion_checker.sv @@
module sdbs_motion_checker #(
  parameter int unsigned PIXEL_COUNT = 131072
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  sdbs_pkg::cfg_idx_t                cfg_idx_i,
  input  logic [sdbs_pkg::PixW-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              req_type_i,
  input  logic [sdbs_pkg::IndexW-1:0]       pixel_index_i,
  input  logic [sdbs_pkg::PixW-1:0]         pixel_value_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic                              foreground_i,
  input  logic [sdbs_pkg::PixW-1:0]         background_level_i,
  input  logic [sdbs_pkg::PixW-1:0]         variance_level_i,
  output int unsigned                       pending_o,
  output int unsigned                       fail_count_o
);
  import sdbs_pkg::*;

  typedef struct packed {
    logic            fg;
    logic [PixW-1:0] bg;
    logic [PixW-1:0] spread;
  } pixel_verdict_t;

  // Shadow copy of the per-pixel model and of the settings
  logic [PixW-1:0]  bg_mem     [PIXEL_COUNT];
  logic [PixW-1:0]  spread_mem [PIXEL_COUNT];
  logic [PixW-1:0]  var_floor;
  logic [PixW-1:0]  var_ceiling;
  logic [GainW-1:0] gain;

  pixel_verdict_t   verdict_q [$];
  pixel_verdict_t   head;
  int unsigned      fails = 0;

  initial begin
    pending_o    = 0;
    fail_count_o = 0;
  end

  // Move a level by one toward its goal
  function automatic logic [PixW-1:0] nudge(input logic [PixW-1:0] level,
                                            input logic [PixW-1:0] goal);
    if (level < goal) return level + 1'b1;
    if (level > goal) return level - 1'b1;
    return level;
  endfunction

  // Work out the result of one pixel transaction and advance the shadow model
  function automatic pixel_verdict_t classify_pixel(input logic              req,
                                                    input logic [IndexW-1:0] idx,
                                                    input logic [PixW-1:0]   pix);
    pixel_verdict_t   res;
    logic             in_range;
    logic [PixW-1:0]  old_bg;
    logic [PixW-1:0]  old_spread;
    logic [PixW-1:0]  diff;
    logic [PixW-1:0]  target;
    logic [ProdW-1:0] prod;
    in_range = (idx < PIXEL_COUNT);
    if (req == REQ_INIT) begin
      res.fg     = 1'b0;
      res.bg     = pix;
      res.spread = var_floor;
    end else begin
      old_bg     = in_range ? bg_mem[idx] : '0;
      old_spread = in_range ? spread_mem[idx] : '0;
      res.bg     = nudge(old_bg, pix);
      diff       = (res.bg > pix) ? res.bg - pix : pix - res.bg;
      prod       = diff * gain;
      target     = (prod > ProdW'(PixMax)) ? PixMax : prod[PixW-1:0];
      res.spread = nudge(old_spread, target);
      // ceiling first, floor wins when the two cross
      if (res.spread > var_ceiling) res.spread = var_ceiling;
      if (res.spread < var_floor) res.spread = var_floor;
      res.fg     = (diff >= res.spread);
    end
    if (in_range) begin
      bg_mem[idx]     = res.bg;
      spread_mem[idx] = res.spread;
    end
    return res;
  endfunction

  function automatic int unsigned field_miss(input string           name,
                                             input logic [PixW-1:0] want,
                                             input logic [PixW-1:0] got);
    if (want === got) return 0;
    $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    return 1;
  endfunction

  // Track settings, queue predictions and compare results
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_floor   = FloorReset;
      var_ceiling = CeilingReset;
      gain        = GainReset;
      verdict_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_VARIANCE_FLOOR:   var_floor   = cfg_data_i;
          CFG_VARIANCE_CEILING: var_ceiling = cfg_data_i;
          CFG_DIFFERENCE_GAIN:  gain        = cfg_data_i[GainW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        verdict_q.push_back(classify_pixel(req_type_i, pixel_index_i, pixel_value_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $error("result with no transaction pending: fg %0d bg %0d var %0d",
                 foreground_i, background_level_i, variance_level_i);
          fails++;
        end else begin
          head  = verdict_q.pop_front();
          fails += field_miss("foreground", head.fg, foreground_i);
          fails += field_miss("background_level", head.bg, background_level_i);
          fails += field_miss("variance_level", head.spread, variance_level_i);
        end
      end
      pending_o <= verdict_q.size();
    end
    fail_count_o <= fails;
  end

endmodule

@@ dv/tb.sv @@
module tb;
  import sdbs_pkg::*;

  localparam int unsigned PIXEL_COUNT = 131072;
  localparam int unsigned PIPE_DEPTH  = 3;
  localparam int unsigned POOL_SIZE   = 8;
  localparam int unsigned SCENE_ITEMS = 116;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [IndexW-1:0] LAST_PIXEL = IndexW'(PIXEL_COUNT - 1);

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TRAIN} stall_mode_e;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  cfg_idx_t          cfg_idx_i     = CFG_VARIANCE_FLOOR;
  logic [PixW-1:0]   cfg_data_i    = '0;
  logic              in_valid_i    = 1'b0;
  logic              req_type_i    = REQ_INIT;
  logic [IndexW-1:0] pixel_index_i = '0;
  logic [PixW-1:0]   pixel_value_i = '0;
  logic              out_stall_i   = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic              foreground_o;
  logic [PixW-1:0]   background_level_o;
  logic [PixW-1:0]   variance_level_o;

  int unsigned       pending;
  int unsigned       fail_count;
  int unsigned       cycles     = 0;
  int unsigned       burst_left = 0;
  bit                valid_on   = 1'b0;
  stall_mode_e       stall_mode = STALL_NONE;
  int unsigned       stall_left = 0;

  // Working set of pixels for one scene
  logic [IndexW-1:0] pool_idx  [POOL_SIZE];
  logic [PixW-1:0]   pool_base [POOL_SIZE];
  bit                pool_live [POOL_SIZE];

  always #2 clk_i = ~clk_i;

  sigma_delta_background_subtract_unit #(
    .PIXEL_COUNT(PIXEL_COUNT)
  ) u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .pixel_index_i      (pixel_index_i),
    .pixel_value_i      (pixel_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .foreground_o       (foreground_o),
    .background_level_o (background_level_o),
    .variance_level_o   (variance_level_o)
  );

  sdbs_motion_checker #(
    .PIXEL_COUNT(PIXEL_COUNT)
  ) u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_i         (in_stall_o),
    .req_type_i         (req_type_i),
    .pixel_index_i      (pixel_index_i),
    .pixel_value_i      (pixel_value_i),
    .out_valid_i        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .foreground_i       (foreground_o),
    .background_level_i (background_level_o),
    .variance_level_i   (variance_level_o),
    .pending_o          (pending),
    .fail_count_o       (fail_count)
  );

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stall the result side in changing patterns
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 64);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 4) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:     out_stall_i <= ((stall_left % 8) < 5);
    endcase
  end

  // Offer one pixel transaction, hold it until taken, then maybe pause
  task automatic push_pixel(input logic              req,
                            input logic [IndexW-1:0] idx,
                            input logic [PixW-1:0]   pix);
    int unsigned gap;
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    pixel_index_i <= idx;
    pixel_value_i <= pix;
    valid_on = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        valid_on = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Wait until every result is back and the pipeline is empty
  task automatic drain();
    if (valid_on) begin
      in_valid_i <= 1'b0;
      valid_on = 1'b0;
    end
    do @(posedge clk_i); while (pending != 0);
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [PixW-1:0]  lo,
                                input logic [PixW-1:0]  hi,
                                input logic [GainW-1:0] gain);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_VARIANCE_FLOOR;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_VARIANCE_CEILING;
    cfg_data_i <= hi;
    @(posedge clk_i);
    // unused upper bits get random content
    cfg_idx_i  <= CFG_DIFFERENCE_GAIN;
    cfg_data_i <= {4'($urandom_range(0, 15)), gain};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [PixW-1:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return PixMax;
      default: return PixW'($urandom_range(0, 255));
    endcase
  endfunction

  // Random scene: a few pixels that sit still, jitter, and now and then jump
  task automatic run_scene(input int unsigned count);
    int unsigned width;
    int unsigned slot;
    int          level;
    width = $urandom_range(1, POOL_SIZE);
    for (int s = 0; s < POOL_SIZE; s++) begin
      case ($urandom_range(0, 5))
        0:       pool_idx[s] = '0;
        1:       pool_idx[s] = LAST_PIXEL;
        default: pool_idx[s] = IndexW'($urandom_range(0, PIXEL_COUNT - 1));
      endcase
      pool_base[s] = pick_level();
      pool_live[s] = 1'b0;
    end
    repeat (count) begin
      slot = $urandom_range(0, width - 1);
      if (!pool_live[slot] || $urandom_range(0, 24) == 0) begin
        pool_live[slot] = 1'b1;
        push_pixel(REQ_INIT, pool_idx[slot], pool_base[slot]);
      end else begin
        level = pool_base[slot];
        case ($urandom_range(0, 9))
          0: begin
            pool_base[slot] = pick_level();
            level = pool_base[slot];
          end
          1:       level = $urandom_range(0, 255);
          default: level = level + int'($urandom_range(0, 6)) - 3;
        endcase
        if (level < 0) level = 0;
        if (level > 255) level = 255;
        push_pixel(REQ_UPDATE, pool_idx[slot], level[PixW-1:0]);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: extremes, saturation, back-to-back on one pixel, re-init
    push_pixel(REQ_INIT,   '0,           8'd0);
    push_pixel(REQ_INIT,   LAST_PIXEL,   8'd255);
    push_pixel(REQ_UPDATE, '0,           8'd255);
    push_pixel(REQ_UPDATE, LAST_PIXEL,   8'd0);
    push_pixel(REQ_UPDATE, '0,           8'd0);
    push_pixel(REQ_UPDATE, '0,           8'd0);
    push_pixel(REQ_UPDATE, '0,           8'd0);
    push_pixel(REQ_INIT,   17'h15555,    8'hAA);
    push_pixel(REQ_UPDATE, 17'h15555,    8'hAA);
    push_pixel(REQ_INIT,   17'h0AAAA,    8'h55);
    push_pixel(REQ_UPDATE, 17'h0AAAA,    8'h73);
    push_pixel(REQ_UPDATE, 17'h0AAAA,    8'h69);
    push_pixel(REQ_UPDATE, 17'h0AAAA,    8'h55);
    push_pixel(REQ_UPDATE, LAST_PIXEL,   8'd255);
    push_pixel(REQ_UPDATE, LAST_PIXEL,   8'd255);
    push_pixel(REQ_INIT,   '0,           8'd128);
    push_pixel(REQ_UPDATE, '0,           8'd128);
    push_pixel(REQ_UPDATE, '0,           8'd149);
    push_pixel(REQ_UPDATE, '0,           8'd150);
    push_pixel(REQ_UPDATE, 17'h15555,    8'h00);
    run_scene(SCENE_ITEMS);

    // Widest clamp range with the largest nominal gain
    apply_settings(8'd0, 8'd255, 4'd8);
    run_scene(SCENE_ITEMS);
    // Floor above ceiling: variance pinned to the floor
    apply_settings(8'd255, 8'd0, 4'd1);
    run_scene(SCENE_ITEMS);
    // Zero gain: product always zero
    apply_settings(8'd0, 8'd255, 4'd0);
    run_scene(SCENE_ITEMS);
    // Gain beyond the nominal range, narrow band
    apply_settings(8'd10, 8'd40, 4'd15);
    run_scene(SCENE_ITEMS);
    repeat (3) begin
      apply_settings(PixW'($urandom_range(0, 63)), PixW'($urandom_range(16, 255)),
                     GainW'($urandom_range(1, 8)));
      run_scene(SCENE_ITEMS);
    end

    drain();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
